### design/apsp_pkg.sv
// Shared constants, beat types and address helpers for the shortest path engine.
package apsp_pkg;

    // Matrix geometry
    localparam int MAX_NODES = 64;
    localparam int DEPTH     = MAX_NODES * MAX_NODES;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);

    // Field widths
    localparam int CMD_W    = 2;
    localparam int FIELD_W  = 6;
    localparam int WEIGHT_W = 16;
    localparam int DIST_W   = 30;
    localparam int SUM_W    = DIST_W + 1;
    localparam int NC_W     = 7;
    localparam int NC_CMP_W = 9;

    localparam logic [DIST_W-1:0] UNREACH          = 30'd1000000000;
    localparam logic [NC_W-1:0]   NODE_COUNT_RESET = 7'd64;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd3;

    // Result kinds
    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [FIELD_W-1:0]  from_node;
        logic [FIELD_W-1:0]  to_node;
        logic [WEIGHT_W-1:0] edge_weight;
    } t_apsp_in;

    typedef struct packed {
        logic              result_kind;
        logic [DIST_W-1:0] path_length;
        logic              reachable;
    } t_apsp_out;

    // Result status from the core to the output stage
    typedef struct packed {
        logic              valid;
        logic              kind;
        logic [DIST_W-1:0] len;
    } t_core_res;

    // Flat matrix address of (row, col)
    function automatic logic [ADDR_W-1:0] node_addr(input logic [NODE_W-1:0] row,
                                                    input logic [NODE_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(MAX_NODES) + ADDR_W'(col);
    endfunction

    // Node index lies inside the matrix
    function automatic logic node_ok(input logic [FIELD_W-1:0] idx);
        return NC_CMP_W'(idx) < NC_CMP_W'(MAX_NODES);
    endfunction

endpackage

### design/apsp_core.sv
// Distance matrix memory with the clear, edge, read and relaxation sequencer.
module apsp_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  apsp_pkg::t_apsp_in     i_item,
    input  logic [apsp_pkg::CNT_W-1:0] i_node_total,
    output logic                   o_busy,
    output apsp_pkg::t_core_res    o_res
);
    import apsp_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CLEAR  = 9'b000000010,
        S_ADD    = 9'b000000100,
        S_READ   = 9'b000001000,
        S_IK_REQ = 9'b000010000,
        S_IK_CHK = 9'b000100000,
        S_ROW    = 9'b001000000,
        S_DRAIN  = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    // Matrix storage
    logic [DIST_W-1:0] mem [DEPTH];
    logic [DIST_W-1:0] r_rd_a, r_rd_b;
    logic [ADDR_W-1:0] addr_a, addr_b, waddr;
    logic [DIST_W-1:0] wdata;
    logic              we;

    // Control registers
    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic [NODE_W-1:0] r_k, n_k, r_i, n_i, r_j, n_j;
    logic              r_p1_valid, n_p1_valid;

    // Payload registers
    logic [NODE_W-1:0]   r_p1_j;
    logic [DIST_W-1:0]   r_ik;
    logic                r_in_range;
    logic [ADDR_W-1:0]   r_acc_addr;
    logic [WEIGHT_W-1:0] r_weight;

    logic             last_i, last_j, last_k, skip_row;
    logic [SUM_W-1:0] sum;

    assign last_i   = (CNT_W'(r_i) + CNT_W'(1)) == i_node_total;
    assign last_j   = (CNT_W'(r_j) + CNT_W'(1)) == i_node_total;
    assign last_k   = (CNT_W'(r_k) + CNT_W'(1)) == i_node_total;
    assign skip_row = r_rd_a >= UNREACH;
    assign sum      = SUM_W'(r_ik) + SUM_W'(r_rd_a);
    assign o_busy   = r_state != S_IDLE;

    // Select read addresses
    always_comb begin
        addr_b = node_addr(r_i, r_j);
        unique case (r_state)
            S_IDLE:   addr_a = node_addr(NODE_W'(i_item.from_node), NODE_W'(i_item.to_node));
            S_IK_REQ: addr_a = node_addr(r_i, r_k);
            S_ROW:    addr_a = node_addr(r_k, r_j);
            default:  addr_a = r_acc_addr;
        endcase
    end

    // Select the write: sweep, edge update or relaxed pair
    always_comb begin
        we    = 1'b0;
        waddr = r_acc_addr;
        wdata = UNREACH;
        priority if (r_state == S_CLEAR) begin
            we    = 1'b1;
            waddr = r_clr_addr;
        end else if (r_state == S_ADD) begin
            we    = r_in_range && (DIST_W'(r_weight) < r_rd_a);
            wdata = DIST_W'(r_weight);
        end else if (r_p1_valid) begin
            we    = (r_rd_a < UNREACH) && (sum < SUM_W'(r_rd_b));
            waddr = node_addr(r_i, r_p1_j);
            wdata = DIST_W'(sum);
        end
    end

    // Memory ports
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd_a <= mem[addr_a];
        r_rd_b <= mem[addr_b];
    end

    // Result beat
    always_comb begin
        o_res.valid = 1'b0;
        o_res.kind  = KIND_DONE;
        o_res.len   = '0;
        if (r_state == S_READ) begin
            o_res.valid = 1'b1;
            o_res.kind  = KIND_READ;
            o_res.len   = r_in_range ? r_rd_a : UNREACH;
        end else if (r_state == S_DONE) begin
            o_res.valid = 1'b1;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_k        = r_k;
        n_i        = r_i;
        n_j        = r_j;
        n_p1_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_item.command)
                        CMD_CLEAR: begin
                            n_clr_addr = '0;
                            n_state    = S_CLEAR;
                        end
                        CMD_ADD:  n_state = S_ADD;
                        CMD_READ: n_state = S_READ;
                        default: begin
                            n_k = '0;
                            n_i = '0;
                            n_state = (i_node_total == '0) ? S_DONE : S_IK_REQ;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IK_REQ: n_state = S_IK_CHK;
            S_IK_CHK, S_DRAIN: begin
                if (r_state == S_IK_CHK && !skip_row) begin
                    n_j     = '0;
                    n_state = S_ROW;
                end else if (last_i) begin
                    n_i = '0;
                    if (last_k) begin
                        n_state = S_DONE;
                    end else begin
                        n_k     = r_k + NODE_W'(1);
                        n_state = S_IK_REQ;
                    end
                end else begin
                    n_i     = r_i + NODE_W'(1);
                    n_state = S_IK_REQ;
                end
            end
            S_ROW: begin
                n_p1_valid = 1'b1;
                n_j        = r_j + NODE_W'(1);
                if (last_j) begin
                    n_state = S_DRAIN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, cleared by reset; reset starts the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_k        <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_p1_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_k        <= n_k;
            r_i        <= n_i;
            r_j        <= n_j;
            r_p1_valid <= n_p1_valid;
        end
    end

    // Capture the accepted beat, the row operand and the pipelined column
    always_ff @(posedge i_clk) begin
        r_p1_j <= r_j;
        if (r_state == S_IK_CHK) begin
            r_ik <= r_rd_a;
        end
        if (r_state == S_IDLE && i_start) begin
            r_in_range <= node_ok(i_item.from_node) && node_ok(i_item.to_node);
            r_acc_addr <= node_addr(NODE_W'(i_item.from_node), NODE_W'(i_item.to_node));
            r_weight   <= i_item.edge_weight;
        end
    end

endmodule

### design/all_pairs_shortest_path.sv
// Top level of the all-pairs shortest path engine: command port, node count and result beat.
//
// Commands are taken when start is high and busy is low. A clear sweeps all
// MAX_NODES*MAX_NODES matrix entries (4096 at 64 nodes) one entry per cycle; the same
// sweep runs right after reset, with busy high. An add edge is a read-modify-write
// and a read is a read of the single distance memory. A compute over n in-use nodes
// fetches and tests each (i,k) entry and skips the row when that entry is
// unreachable; otherwise it relaxes the row one column per cycle through the memory's
// two read ports and one write port, followed by a drain state, and it ends in a
// final done state.
// Read and compute-done results come out as one-cycle beats on o_result marked by
// o_result_strobe in the cycle after the command finishes; the receiver cannot stall
// them. Write node_count only while busy is low.
module all_pairs_shortest_path (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  apsp_pkg::t_apsp_in         i_item,
    input  logic                       i_cfg_we,
    input  logic [apsp_pkg::NC_W-1:0]  i_cfg_data,
    output logic                       o_result_strobe,
    output apsp_pkg::t_apsp_out        o_result
);
    import apsp_pkg::*;

    logic [NC_W-1:0]  r_node_count;
    logic [CNT_W-1:0] node_total;
    t_core_res        core_res;
    logic             r_strobe;
    t_apsp_out        r_result;

    // Clamp the node count to the matrix size
    assign node_total = (NC_CMP_W'(r_node_count) > NC_CMP_W'(MAX_NODES))
                      ? CNT_W'(MAX_NODES) : CNT_W'(r_node_count);

    apsp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start && !busy),
        .i_item       (i_item),
        .i_node_total (node_total),
        .o_busy       (busy),
        .o_res        (core_res)
    );

    // Hold the node count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_data;
        end
    end

    // Register the result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= core_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.result_kind <= core_res.kind;
        r_result.path_length <= core_res.len;
        r_result.reachable   <= (core_res.kind == KIND_READ) && (core_res.len < UNREACH);
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

endmodule
